// File: rtl/sse_pkg.sv
// Package for the string image escaper: character codes, register indexes
// and the result bundle passed from the encoder to the serializer.
// No dependencies.
`timescale 1ns / 1ps

package sse_pkg;

    localparam int ResultsMax = 8;
    localparam int CountWidth = 11;
    localparam int LimitWidth = 10;

    localparam logic [CountWidth-1:0] CountMax = 11'd2047;

    localparam logic [7:0] CharQuote     = 8'h22;
    localparam logic [7:0] CharBackslash = 8'h5C;
    localparam logic [7:0] CharDot       = 8'h2E;
    localparam logic [7:0] CharZero      = 8'h30;
    localparam logic [7:0] CharSpace     = 8'h20;
    localparam logic [7:0] CharDel       = 8'h7F;
    localparam logic [7:0] CharLowerB    = 8'h62;
    localparam logic [7:0] CharLowerT    = 8'h74;
    localparam logic [7:0] CharLowerN    = 8'h6E;
    localparam logic [7:0] ByteBackspace = 8'h08;
    localparam logic [7:0] ByteTab       = 8'h09;
    localparam logic [7:0] ByteNewline   = 8'h0A;

    localparam logic RegLongForm  = 1'b0;
    localparam logic RegBodyLimit = 1'b1;

    typedef struct packed {
        logic [ResultsMax-1:0][7:0] chars;
        logic [2:0]                 last_idx;
        logic                       has_chars;
        logic                       image_end;
    } sse_result_t;

    typedef struct packed {
        logic [CountWidth-1:0] body_count;
        logic                  truncated;
    } sse_state_t;

endpackage

// File: rtl/sse_encoder.sv
// Combinational encoder: turns one registered input byte and the string state
// into up to eight image characters and the next string state.
// Depends on sse_pkg.
`timescale 1ns / 1ps

module sse_encoder
(
    input  logic [7:0]                     data_byte,
    input  logic                           first_byte,
    input  logic                           last_byte,
    input  logic                           empty_string,
    input  logic                           long_form,
    input  logic [sse_pkg::LimitWidth-1:0] body_limit,
    input  sse_pkg::sse_state_t            state_cur,
    output sse_pkg::sse_state_t            state_next,
    output sse_pkg::sse_result_t           result
);

    logic [3:0][7:0] body_chars;
    logic [2:0]      body_n;
    logic [2:0][7:0] tail_chars;
    logic [1:0]      tail_n;
    logic [sse_pkg::CountWidth-1:0] base_count;
    logic [sse_pkg::CountWidth:0]   count_sum;
    logic [sse_pkg::CountWidth-1:0] count_sat;
    logic            cut;
    logic [3:0]      total_n;

    always_comb
    begin
        body_chars = '0;
        if (data_byte >= sse_pkg::CharSpace && data_byte < sse_pkg::CharDel)
        begin
            body_chars[0] = data_byte;
            body_n = 3'd1;
        end
        else if (data_byte == sse_pkg::ByteBackspace)
        begin
            body_chars[0] = sse_pkg::CharBackslash;
            body_chars[1] = sse_pkg::CharLowerB;
            body_n = 3'd2;
        end
        else if (data_byte == sse_pkg::ByteTab)
        begin
            body_chars[0] = sse_pkg::CharBackslash;
            body_chars[1] = sse_pkg::CharLowerT;
            body_n = 3'd2;
        end
        else if (data_byte == sse_pkg::ByteNewline)
        begin
            body_chars[0] = sse_pkg::CharBackslash;
            body_chars[1] = sse_pkg::CharLowerN;
            body_n = 3'd2;
        end
        else
        begin
            body_chars[0] = sse_pkg::CharBackslash;
            body_chars[1] = sse_pkg::CharZero + {6'd0, data_byte[7:6]};
            body_chars[2] = sse_pkg::CharZero + {5'd0, data_byte[5:3]};
            body_chars[3] = sse_pkg::CharZero + {5'd0, data_byte[2:0]};
            body_n = 3'd4;
        end
    end

    always_comb
    begin
        base_count = first_byte ? '0 : state_cur.body_count;
        count_sum  = {1'b0, base_count} + {9'd0, body_n};
        count_sat  = count_sum[sse_pkg::CountWidth] ? sse_pkg::CountMax
                                                    : count_sum[sse_pkg::CountWidth-1:0];
        cut = !long_form && (count_sat >= {1'b0, body_limit});

        tail_chars = '0;
        if (cut)
        begin
            tail_chars = {3{sse_pkg::CharDot}};
            tail_n = 2'd3;
        end
        else if (last_byte)
        begin
            tail_chars[0] = sse_pkg::CharQuote;
            tail_n = 2'd1;
        end
        else
        begin
            tail_n = 2'd0;
        end
    end

    always_comb
    begin
        logic [3:0] rel;
        logic [3:0] tail_rel;
        result = '0;
        total_n = {3'd0, first_byte} + {1'b0, body_n} + {2'd0, tail_n};
        for (int k = 0; k < sse_pkg::ResultsMax; k++)
        begin
            rel = 4'(k) - {3'd0, first_byte};
            tail_rel = rel - {1'b0, body_n};
            if (first_byte && k == 0)
            begin
                result.chars[k] = sse_pkg::CharQuote;
            end
            else if (rel < {1'b0, body_n})
            begin
                result.chars[k] = body_chars[rel[1:0]];
            end
            else if (tail_rel < 4'd3)
            begin
                result.chars[k] = tail_chars[tail_rel[1:0]];
            end
        end

        if (empty_string)
        begin
            result.chars        = '0;
            result.chars[0]     = sse_pkg::CharQuote;
            result.chars[1]     = sse_pkg::CharQuote;
            result.last_idx     = 3'd1;
            result.has_chars    = 1'b1;
            result.image_end    = 1'b1;
            state_next          = '0;
        end
        else if (!first_byte && state_cur.truncated)
        begin
            result              = '0;
            state_next          = state_cur;
        end
        else
        begin
            result.last_idx     = 3'(total_n - 4'd1);
            result.has_chars    = 1'b1;
            result.image_end    = cut || last_byte;
            state_next.body_count = count_sat;
            state_next.truncated  = cut;
        end
    end

endmodule

// File: rtl/sse_serializer.sv
// Result buffer that holds the characters of one input item and hands them
// to the output stream one per cycle while m_axis_tready is high. Depends on sse_pkg.
`timescale 1ns / 1ps

module sse_serializer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  sse_pkg::sse_result_t load_result,
    output logic                 free,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // out_char
    output logic                 m_axis_tlast,   // run_last
    output logic [0:0]           m_axis_tuser    // image_end
);

    logic [sse_pkg::ResultsMax-1:0][7:0] chars_reg;
    logic [2:0] last_idx_reg;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       end_reg;
    logic       valid_reg;
    logic       valid_next;
    logic       at_last;

    assign at_last = idx_reg == last_idx_reg;
    assign free    = !valid_reg || (m_axis_tready && at_last);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (valid_reg && m_axis_tready)
        begin
            if (at_last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chars_reg    <= load_result.chars;
            last_idx_reg <= load_result.last_idx;
            end_reg      <= load_result.image_end;
        end
    end

    assign m_axis_tvalid   = valid_reg;
    assign m_axis_tdata    = chars_reg[idx_reg];
    assign m_axis_tlast    = at_last;
    assign m_axis_tuser[0] = at_last && end_reg;

endmodule

// File: rtl/string_image_escaper.sv
// Top level of the string image escaper: input register, string state,
// configuration registers, encoder and output serializer.
// Depends on sse_pkg, sse_encoder and sse_serializer.
//
// Channel   Direction  Handshake            Payload
// s_axis    in         tvalid/tready        tdata=data_byte, tlast=last_byte,
//                                           tuser={empty_string, first_byte}
// m_axis    out        tvalid/tready        tdata=out_char, tlast=run_last,
//                                           tuser=image_end
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An input byte produces up to eight characters, which the serializer drives one per
// transaction; a byte that produces nothing leaves the input register once the
// serializer is free.
// The next byte waits in the input register and is encoded when the serializer finishes
// its last character, so runs flow without gaps.
// Reset clears the string state and sets long_form to 0 and body_limit to 60.
// Configuration writes are always accepted.
`timescale 1ns / 1ps

module string_image_escaper
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // last_byte
    input  logic [1:0]  s_axis_tuser,   // first_byte, empty_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_char
    output logic        m_axis_tlast,   // run_last
    output logic [0:0]  m_axis_tuser,   // image_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data
);

    logic       in_valid_reg;
    logic [7:0] data_byte_reg;
    logic       first_byte_reg;
    logic       last_byte_reg;
    logic       empty_string_reg;
    logic       long_form_reg;
    logic [sse_pkg::LimitWidth-1:0] body_limit_reg;
    sse_pkg::sse_state_t  state_reg;
    sse_pkg::sse_state_t  state_next;
    sse_pkg::sse_result_t enc_result;
    logic       ser_free;
    logic       advance;
    logic       s_accept;

    assign advance       = in_valid_reg && ser_free;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            state_reg      <= '0;
            long_form_reg  <= 1'b0;
            body_limit_reg <= 10'd60;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    sse_pkg::RegLongForm:  long_form_reg  <= cfg_data[0];
                    sse_pkg::RegBodyLimit: body_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            data_byte_reg    <= s_axis_tdata;
            first_byte_reg   <= s_axis_tuser[0];
            last_byte_reg    <= s_axis_tlast;
            empty_string_reg <= s_axis_tuser[1];
        end
    end

    sse_encoder u_encoder
    (
        .data_byte    (data_byte_reg),
        .first_byte   (first_byte_reg),
        .last_byte    (last_byte_reg),
        .empty_string (empty_string_reg),
        .long_form    (long_form_reg),
        .body_limit   (body_limit_reg),
        .state_cur    (state_reg),
        .state_next   (state_next),
        .result       (enc_result)
    );

    sse_serializer u_serializer
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && enc_result.has_chars),
        .load_result   (enc_result),
        .free          (ser_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("image end flagged on a character that does not end its run");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready && in_valid_reg |=> in_valid_reg)
        else $error("input item left its register while the output was stalled");

    a_trunc_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.truncated) |-> $past(advance))
        else $error("truncation flag set without an encoded item");

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for string_image_escaper: a directed table, a short long-form run
// and random strings in four phases of source idling and sink stalls, checked by typed rows or a local model.
// Depends on sse_pkg and the string_image_escaper RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int CycleLimit = 200000;
    localparam int SettleCycles = 8;
    localparam int DirRows = 26;

    typedef enum logic {RowItem, RowConfig} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        reg_sel;
        logic [9:0]  value;
        logic        is_first;
        logic        is_last;
        logic        is_empty;
        int          exp_n;
        logic [63:0] exp_str;
        logic        exp_end;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       image_end;
    } image_char_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic        s_axis_tlast;   // last_byte
    logic [1:0]  s_axis_tuser;   // first_byte, empty_string
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // out_char
    logic        m_axis_tlast;   // run_last
    logic [0:0]  m_axis_tuser;   // image_end
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [9:0]  cfg_data;

    image_char_t                    image_q[$];
    image_char_t                    got_char;
    logic                           mdl_long_form = 1'b0;
    logic [sse_pkg::LimitWidth-1:0] mdl_body_limit = 10'd60;
    logic [sse_pkg::CountWidth-1:0] mdl_body_count = '0;
    logic                           mdl_truncated = 1'b0;
    int                             src_idle_pct = 0;
    int                             snk_stall_pct = 0;
    int                             err_count = 0;
    int                             cycle_count = 0;

    stim_row_t dir_rows [DirRows] = '{
        '{RowItem,   1'b0,                  10'h041, 1'b1, 1'b1, 1'b1, 2, "\"\"", 1'b1},
        '{RowItem,   1'b0,                  10'h020, 1'b1, 1'b1, 1'b0, 3, "\" \"", 1'b1},
        '{RowItem,   1'b0,                  10'h07E, 1'b1, 1'b0, 1'b0, 2, "\"~", 1'b0},
        '{RowItem,   1'b0,                  10'h07F, 1'b0, 1'b0, 1'b0, 4, "\\177", 1'b0},
        '{RowItem,   1'b0,                  10'h008, 1'b0, 1'b0, 1'b0, 2, "\\b", 1'b0},
        '{RowItem,   1'b0,                  10'h009, 1'b0, 1'b0, 1'b0, 2, "\\t", 1'b0},
        '{RowItem,   1'b0,                  10'h00A, 1'b0, 1'b0, 1'b0, 2, "\\n", 1'b0},
        '{RowItem,   1'b0,                  10'h000, 1'b0, 1'b0, 1'b0, 4, "\\000", 1'b0},
        '{RowItem,   1'b0,                  10'h0FF, 1'b0, 1'b0, 1'b0, 4, "\\377", 1'b0},
        '{RowItem,   1'b0,                  10'h080, 1'b0, 1'b0, 1'b0, 4, "\\200", 1'b0},
        '{RowItem,   1'b0,                  10'h01F, 1'b0, 1'b0, 1'b0, -1, 64'd0, 1'b0},
        '{RowItem,   1'b0,                  10'h00B, 1'b0, 1'b1, 1'b0, 5, "\\013\"", 1'b1},
        '{RowItem,   1'b0,                  10'h041, 1'b0, 1'b1, 1'b0, 2, "A\"", 1'b1},
        '{RowConfig, sse_pkg::RegBodyLimit, 10'd3,   1'b0, 1'b0, 1'b0, 0, 64'd0, 1'b0},
        '{RowItem,   1'b0,                  10'h061, 1'b1, 1'b0, 1'b0, 2, "\"a", 1'b0},
        '{RowItem,   1'b0,                  10'h062, 1'b0, 1'b0, 1'b0, -1, 64'd0, 1'b0},
        '{RowItem,   1'b0,                  10'h063, 1'b0, 1'b0, 1'b0, 4, "c...", 1'b1},
        '{RowItem,   1'b0,                  10'h064, 1'b0, 1'b0, 1'b0, 0, 64'd0, 1'b0},
        '{RowItem,   1'b0,                  10'h065, 1'b0, 1'b1, 1'b0, 0, 64'd0, 1'b0},
        '{RowItem,   1'b0,                  10'h001, 1'b1, 1'b1, 1'b0, 8, "\"\\001...", 1'b1},
        '{RowConfig, sse_pkg::RegBodyLimit, 10'd0,   1'b0, 1'b0, 1'b0, 0, 64'd0, 1'b0},
        '{RowItem,   1'b0,                  10'h071, 1'b1, 1'b0, 1'b0, 5, "\"q...", 1'b1},
        '{RowItem,   1'b0,                  10'h0A5, 1'b0, 1'b0, 1'b1, 2, "\"\"", 1'b1},
        '{RowConfig, sse_pkg::RegLongForm,  10'd1,   1'b0, 1'b0, 1'b0, 0, 64'd0, 1'b0},
        '{RowItem,   1'b0,                  10'h07A, 1'b1, 1'b0, 1'b0, -1, 64'd0, 1'b0},
        '{RowItem,   1'b0,                  10'h005, 1'b0, 1'b1, 1'b0, 5, "\\005\"", 1'b1}
    };

    string_image_escaper DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("ERROR cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    // Escapes one input byte and updates the string state; returns the character count.
    function automatic int escape_byte(input logic [7:0] b, input logic is_first,
                                       input logic is_last, input logic is_empty,
                                       output logic [sse_pkg::ResultsMax-1:0][7:0] chars,
                                       output logic ends);
        int n;
        int body;
        int sum;
        n = 0;
        body = 0;
        ends = 1'b0;
        chars = '0;
        if (is_empty)
        begin
            mdl_body_count = '0;
            mdl_truncated = 1'b0;
            chars[0] = sse_pkg::CharQuote;
            chars[1] = sse_pkg::CharQuote;
            ends = 1'b1;
            return 2;
        end
        if (is_first)
        begin
            mdl_body_count = '0;
            mdl_truncated = 1'b0;
            chars[n] = sse_pkg::CharQuote;
            n++;
        end
        else if (mdl_truncated)
        begin
            return 0;
        end
        if (b >= sse_pkg::CharSpace && b < sse_pkg::CharDel)
        begin
            chars[n] = b;
            n++;
            body = 1;
        end
        else if (b == sse_pkg::ByteBackspace || b == sse_pkg::ByteTab
                 || b == sse_pkg::ByteNewline)
        begin
            chars[n] = sse_pkg::CharBackslash;
            chars[n + 1] = (b == sse_pkg::ByteBackspace) ? sse_pkg::CharLowerB :
                           (b == sse_pkg::ByteTab) ? sse_pkg::CharLowerT : sse_pkg::CharLowerN;
            n += 2;
            body = 2;
        end
        else
        begin
            chars[n] = sse_pkg::CharBackslash;
            chars[n + 1] = sse_pkg::CharZero + {6'd0, b[7:6]};
            chars[n + 2] = sse_pkg::CharZero + {5'd0, b[5:3]};
            chars[n + 3] = sse_pkg::CharZero + {5'd0, b[2:0]};
            n += 4;
            body = 4;
        end
        sum = int'(mdl_body_count) + body;
        mdl_body_count = (sum > int'(sse_pkg::CountMax)) ? sse_pkg::CountMax
                                                         : sum[sse_pkg::CountWidth-1:0];
        if (!mdl_long_form && mdl_body_count >= {1'b0, mdl_body_limit})
        begin
            chars[n] = sse_pkg::CharDot;
            chars[n + 1] = sse_pkg::CharDot;
            chars[n + 2] = sse_pkg::CharDot;
            n += 3;
            mdl_truncated = 1'b1;
            ends = 1'b1;
        end
        else if (is_last)
        begin
            chars[n] = sse_pkg::CharQuote;
            n++;
            ends = 1'b1;
        end
        return n;
    endfunction

    // A typed count of -1 means the expected characters come from the model.
    task automatic send_item(input logic [7:0] b, input logic is_first, input logic is_last,
                             input logic is_empty, input int typed_n,
                             input logic [63:0] typed_str, input logic typed_end,
                             output int n_res);
        logic [sse_pkg::ResultsMax-1:0][7:0] chars;
        logic ends;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= is_last;
        s_axis_tuser <= {is_empty, is_first};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_res = escape_byte(b, is_first, is_last, is_empty, chars, ends);
        if (typed_n >= 0)
        begin
            for (int k = 0; k < typed_n; k++)
                image_q.push_back(image_char_t'{typed_str[(typed_n - 1 - k) * 8 +: 8],
                                                k == typed_n - 1,
                                                (k == typed_n - 1) && typed_end});
        end
        else
        begin
            for (int k = 0; k < n_res; k++)
                image_q.push_back(image_char_t'{chars[k], k == n_res - 1,
                                                (k == n_res - 1) && ends});
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (image_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [9:0] value, input logic keep_valid);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (!keep_valid)
            cfg_valid <= 1'b0;
        if (idx == sse_pkg::RegLongForm)
            mdl_long_form = value[0];
        else
            mdl_body_limit = value;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 8'($urandom_range(32, 126));
        else if (r < 65)
            return 8'($urandom_range(8, 10));
        return 8'($urandom_range(255));
    endfunction

    // Mostly well-formed strings; one pick in ten is a stray item with random flags.
    task automatic run_random_phase(input int target, input logic pause_midway);
        int sent;
        int len;
        int n_res;
        logic pending_pause;
        sent = 0;
        pending_pause = pause_midway;
        while (sent < target)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                          $urandom_range(3) == 0, -1, 64'd0, 1'b0, n_res);
                if (n_res > 0)
                    sent++;
            end
            else
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                begin
                    send_item(pick_byte(), i == 0, i == len - 1, 1'b0, -1, 64'd0, 1'b0, n_res);
                    if (n_res > 0)
                        sent++;
                end
            end
            if (pending_pause && sent >= target / 2)
            begin
                pending_pause = 1'b0;
                drain_results();
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (image_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character %h", m_axis_tdata));
            end
            else
            begin
                got_char = image_q.pop_front();
                if (m_axis_tdata !== got_char.ch)
                    report_mismatch($sformatf("out_char %h, expected %h",
                                              m_axis_tdata, got_char.ch));
                if (m_axis_tlast !== got_char.run_last)
                    report_mismatch($sformatf("run_last %b, expected %b",
                                              m_axis_tlast, got_char.run_last));
                if (m_axis_tuser[0] !== got_char.image_end)
                    report_mismatch($sformatf("image_end %b, expected %b",
                                              m_axis_tuser[0], got_char.image_end));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    initial
    begin
        int n_res;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = sse_pkg::RegLongForm;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DirRows; r++)
        begin
            if (dir_rows[r].kind == RowConfig)
            begin
                drain_results();
                write_reg(dir_rows[r].reg_sel, dir_rows[r].value, 1'b0);
            end
            else
            begin
                send_item(dir_rows[r].value[7:0], dir_rows[r].is_first, dir_rows[r].is_last,
                          dir_rows[r].is_empty, dir_rows[r].exp_n, dir_rows[r].exp_str,
                          dir_rows[r].exp_end, n_res);
            end
        end

        // Long form never cuts a string, however many escapes it collects.
        for (int i = 0; i < 6; i++)
            send_item(8'hFF, i == 0, 1'b0, 1'b0, -1, 64'd0, 1'b0, n_res);
        drain_results();
        write_reg(sse_pkg::RegLongForm, 10'd0, 1'b1);
        write_reg(sse_pkg::RegBodyLimit, 10'd1023, 1'b0);
        send_item(8'h6B, 1'b0, 1'b0, 1'b0, -1, 64'd0, 1'b0, n_res);
        send_item(8'h00, 1'b0, 1'b0, 1'b1, -1, 64'd0, 1'b0, n_res);

        for (int ph = 0; ph < 4; ph++)
        begin
            drain_results();
            case (ph)
                0:
                begin
                    write_reg(sse_pkg::RegLongForm, 10'd0, 1'b1);
                    write_reg(sse_pkg::RegBodyLimit, 10'($urandom_range(4, 30)), 1'b0);
                    src_idle_pct = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    write_reg(sse_pkg::RegLongForm, 10'd1, 1'b1);
                    write_reg(sse_pkg::RegBodyLimit, 10'($urandom_range(1023)), 1'b0);
                    src_idle_pct = 62;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    write_reg(sse_pkg::RegLongForm, 10'd0, 1'b1);
                    write_reg(sse_pkg::RegBodyLimit, 10'd1, 1'b0);
                    src_idle_pct = 0;
                    snk_stall_pct = 62;
                end
                default:
                begin
                    write_reg(sse_pkg::RegLongForm, 10'd0, 1'b1);
                    write_reg(sse_pkg::RegBodyLimit, 10'($urandom_range(4, 30)), 1'b0);
                    src_idle_pct = 16;
                    snk_stall_pct = 16;
                end
            endcase
            run_random_phase(16, ph == 1);
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (image_q.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived", image_q.size()));
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
rtl/sse_pkg.sv
rtl/sse_encoder.sv
rtl/sse_serializer.sv
rtl/string_image_escaper.sv
dv/tb_top.sv
